### hdl/lfgia_pkg.sv
// Shared types, constants and codes of the lowest-free-gate interval allocator.
package lfgia_pkg;

    localparam int MAX_GATES  = 256;
    localparam int GATE_IDX_W = $clog2(MAX_GATES);
    localparam int STEP_W     = $clog2(MAX_GATES + 2);
    localparam int CFG_W      = 9;
    localparam int TIME_W     = 32;
    localparam int USE_W      = 20;
    localparam int SUM_W      = USE_W + GATE_IDX_W;
    localparam int TOT_W      = SUM_W + 1;
    localparam int BEST_W     = 21;

    localparam logic [USE_W-1:0]  USE_MAX       = {USE_W{1'b1}};
    localparam logic [BEST_W-1:0] BEST_MAX      = {BEST_W{1'b1}};
    localparam logic [CFG_W-1:0]  GATE_CNT_RST  = CFG_W'(MAX_GATES);

    localparam logic [1:0] CMD_REQ_A  = 2'd0;
    localparam logic [1:0] CMD_REQ_B  = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] departure;
    } req_t;

    typedef struct packed {
        logic              placed;
        logic [CFG_W-1:0]  gate;
        logic [BEST_W-1:0] best_total;
    } rsp_t;

    typedef struct packed {
        logic              load;
        logic              enc;
        logic              upd;
        logic              clr;
        logic              sum_rd;
        logic              sum_acc;
        logic              best_init;
        logic              spl_rd;
        logic              spl_acc;
        logic              spl_cmp;
        logic [STEP_W-1:0] step;
    } ctl_cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] n;
    } dp_stat_t;

endpackage

### hdl/lfgia_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfgia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/lfgia_datapath.sv
// Datapath: departure registers, free-gate search, use-count RAMs and split accumulator.
module lfgia_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [lfgia_pkg::CFG_W-1:0] cfg_data,
    input  lfgia_pkg::req_t          req,
    input  lfgia_pkg::ctl_cmd_t      ctl,
    output lfgia_pkg::dp_stat_t      stat,
    output lfgia_pkg::rsp_t          rsp
);

    logic [lfgia_pkg::CFG_W-1:0]      gate_count_reg;
    logic [lfgia_pkg::CFG_W-1:0]      eff_n;
    logic [lfgia_pkg::TIME_W-1:0]     dep_a_reg [lfgia_pkg::MAX_GATES];
    logic [lfgia_pkg::TIME_W-1:0]     dep_b_reg [lfgia_pkg::MAX_GATES];
    logic [lfgia_pkg::MAX_GATES-1:0]  free_reg;
    logic [lfgia_pkg::MAX_GATES-1:0]  free_next;
    logic [lfgia_pkg::MAX_GATES-1:0]  lowest;
    logic [lfgia_pkg::GATE_IDX_W-1:0] enc_idx;
    logic                             enc_found;
    logic                             cls_reg;
    logic [lfgia_pkg::TIME_W-1:0]     departure_reg;
    logic                             found_reg;
    logic [lfgia_pkg::GATE_IDX_W-1:0] idx_reg;
    logic                             placed_reg;
    logic [lfgia_pkg::CFG_W-1:0]      gate_reg;
    logic [lfgia_pkg::SUM_W-1:0]      a_sum_reg;
    logic [lfgia_pkg::SUM_W-1:0]      b_rem_reg;
    logic [lfgia_pkg::TOT_W-1:0]      best_reg;
    logic [lfgia_pkg::TOT_W-1:0]      split_sum;
    logic [lfgia_pkg::STEP_W-1:0]     step_m1;
    logic [lfgia_pkg::STEP_W-1:0]     n_minus_step;
    logic [lfgia_pkg::GATE_IDX_W-1:0] raddr_a;
    logic [lfgia_pkg::GATE_IDX_W-1:0] raddr_b;
    logic [lfgia_pkg::GATE_IDX_W-1:0] waddr;
    logic [lfgia_pkg::USE_W-1:0]      rdata_a;
    logic [lfgia_pkg::USE_W-1:0]      rdata_b;
    logic [lfgia_pkg::USE_W-1:0]      use_sel;
    logic [lfgia_pkg::USE_W-1:0]      use_inc;
    logic [lfgia_pkg::USE_W-1:0]      wdata;
    logic                             we_a;
    logic                             we_b;

    assign eff_n = (gate_count_reg > lfgia_pkg::GATE_CNT_RST) ? lfgia_pkg::GATE_CNT_RST
                                                               : gate_count_reg;
    assign stat.n = eff_n;

    // Compare every gate of the requested class against the arrival in parallel.
    always_comb
    begin
        logic [lfgia_pkg::TIME_W-1:0] cand;
        cand = '0;
        for (int j = 0; j < lfgia_pkg::MAX_GATES; j++)
        begin
            cand = req.cmd[0] ? dep_b_reg[j] : dep_a_reg[j];
            free_next[j] = (lfgia_pkg::CFG_W'(j) < eff_n) && (cand <= req.arrival);
        end
    end

    // Isolate the lowest free gate, then encode its index.
    assign lowest    = free_reg & (~free_reg + lfgia_pkg::MAX_GATES'(1));
    assign enc_found = |free_reg;

    always_comb
    begin
        enc_idx = '0;
        for (int j = 0; j < lfgia_pkg::MAX_GATES; j++)
        begin
            if (lowest[j])
            begin
                enc_idx = enc_idx | lfgia_pkg::GATE_IDX_W'(j);
            end
        end
    end

    assign step_m1      = ctl.step - lfgia_pkg::STEP_W'(1);
    assign n_minus_step = lfgia_pkg::STEP_W'(eff_n) - ctl.step;

    assign raddr_a = ctl.enc ? enc_idx : step_m1[lfgia_pkg::GATE_IDX_W-1:0];
    assign raddr_b = ctl.enc    ? enc_idx :
                     ctl.sum_rd ? ctl.step[lfgia_pkg::GATE_IDX_W-1:0]
                                : n_minus_step[lfgia_pkg::GATE_IDX_W-1:0];

    assign use_sel = cls_reg ? rdata_b : rdata_a;
    assign use_inc = (use_sel == lfgia_pkg::USE_MAX) ? use_sel
                                                      : use_sel + lfgia_pkg::USE_W'(1);
    assign wdata   = ctl.clr ? '0 : use_inc;
    assign waddr   = ctl.clr ? ctl.step[lfgia_pkg::GATE_IDX_W-1:0] : idx_reg;
    assign we_a    = ctl.clr || (ctl.upd && found_reg && !cls_reg);
    assign we_b    = ctl.clr || (ctl.upd && found_reg && cls_reg);

    lfgia_ram #(
        .WIDTH (lfgia_pkg::USE_W),
        .DEPTH (lfgia_pkg::MAX_GATES)
    ) u_use_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    lfgia_ram #(
        .WIDTH (lfgia_pkg::USE_W),
        .DEPTH (lfgia_pkg::MAX_GATES)
    ) u_use_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    assign split_sum = lfgia_pkg::TOT_W'(a_sum_reg) + lfgia_pkg::TOT_W'(b_rem_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_count_reg <= lfgia_pkg::GATE_CNT_RST;
        end
        else if (cfg_we)
        begin
            gate_count_reg <= cfg_data;
        end
    end

    // Departure registers start at zero, so an unused gate is free for any arrival.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < lfgia_pkg::MAX_GATES; j++)
            begin
                dep_a_reg[j] <= '0;
                dep_b_reg[j] <= '0;
            end
        end
        else if (ctl.enc && enc_found)
        begin
            if (cls_reg)
            begin
                dep_b_reg[enc_idx] <= departure_reg;
            end
            else
            begin
                dep_a_reg[enc_idx] <= departure_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cls_reg       <= req.cmd[0];
            departure_reg <= req.departure;
            free_reg      <= free_next;
            placed_reg    <= 1'b0;
            gate_reg      <= '0;
            a_sum_reg     <= '0;
            b_rem_reg     <= '0;
            best_reg      <= '0;
        end
        if (ctl.enc)
        begin
            found_reg  <= enc_found;
            idx_reg    <= enc_idx;
            placed_reg <= enc_found;
            gate_reg   <= enc_found ? lfgia_pkg::CFG_W'(enc_idx) + lfgia_pkg::CFG_W'(1) : '0;
        end
        if (ctl.sum_acc)
        begin
            b_rem_reg <= b_rem_reg + lfgia_pkg::SUM_W'(rdata_b);
        end
        if (ctl.best_init)
        begin
            best_reg <= lfgia_pkg::TOT_W'(b_rem_reg);
        end
        if (ctl.spl_acc)
        begin
            a_sum_reg <= a_sum_reg + lfgia_pkg::SUM_W'(rdata_a);
            b_rem_reg <= b_rem_reg - lfgia_pkg::SUM_W'(rdata_b);
        end
        if (ctl.spl_cmp && (split_sum > best_reg))
        begin
            best_reg <= split_sum;
        end
    end

    assign rsp.placed     = placed_reg;
    assign rsp.gate       = gate_reg;
    assign rsp.best_total = (best_reg > lfgia_pkg::TOT_W'(lfgia_pkg::BEST_MAX))
                            ? lfgia_pkg::BEST_MAX : best_reg[lfgia_pkg::BEST_W-1:0];

endmodule

### hdl/lfgia_ctrl.sv
// Controller: clearing pass, request sequencing and the finish walk over the gates.
module lfgia_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           cmd,
    input  lfgia_pkg::dp_stat_t  stat,
    output lfgia_pkg::ctl_cmd_t  ctl,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ENC,
        ST_UPDATE,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_SPL_RD,
        ST_SPL_ACC,
        ST_SPL_CMP,
        ST_FIN_DONE
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [lfgia_pkg::STEP_W-1:0] step_reg;
    logic [lfgia_pkg::STEP_W-1:0] step_next;
    logic                         busy_reg;
    logic                         done_reg;
    logic                         accept;
    logic [lfgia_pkg::STEP_W-1:0] n_step;

    assign accept = start && !busy_reg;
    assign n_step = lfgia_pkg::STEP_W'(stat.n);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ctl        = '0;
        ctl.step   = step_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr = 1'b1;
                if (step_reg == lfgia_pkg::STEP_W'(lfgia_pkg::MAX_GATES - 1))
                begin
                    state_next = ST_IDLE;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + lfgia_pkg::STEP_W'(1);
                end
            end
            ST_IDLE, ST_UPDATE:
            begin
                ctl.upd    = (state_reg == ST_UPDATE);
                state_next = ST_IDLE;
                if (accept)
                begin
                    ctl.load = 1'b1;
                    case (cmd)
                        lfgia_pkg::CMD_REQ_A, lfgia_pkg::CMD_REQ_B:
                        begin
                            state_next = ST_ENC;
                        end
                        lfgia_pkg::CMD_FINISH:
                        begin
                            state_next = ST_SUM_RD;
                            step_next  = '0;
                        end
                        default:
                        begin
                            state_next = ST_FIN_DONE;
                        end
                    endcase
                end
            end
            ST_ENC:
            begin
                ctl.enc    = 1'b1;
                state_next = ST_UPDATE;
            end
            // First pass: total of class B over all effective gates.
            ST_SUM_RD:
            begin
                if (step_reg == n_step)
                begin
                    ctl.best_init = 1'b1;
                    step_next     = lfgia_pkg::STEP_W'(1);
                    state_next    = ST_SPL_RD;
                end
                else
                begin
                    ctl.sum_rd = 1'b1;
                    state_next = ST_SUM_ACC;
                end
            end
            ST_SUM_ACC:
            begin
                ctl.sum_acc = 1'b1;
                step_next   = step_reg + lfgia_pkg::STEP_W'(1);
                state_next  = ST_SUM_RD;
            end
            // Second pass: grow the class A prefix, shrink the class B prefix.
            ST_SPL_RD:
            begin
                if (step_reg > n_step)
                begin
                    state_next = ST_FIN_DONE;
                end
                else
                begin
                    ctl.spl_rd = 1'b1;
                    state_next = ST_SPL_ACC;
                end
            end
            ST_SPL_ACC:
            begin
                ctl.spl_acc = 1'b1;
                state_next  = ST_SPL_CMP;
            end
            ST_SPL_CMP:
            begin
                ctl.spl_cmp = 1'b1;
                step_next   = step_reg + lfgia_pkg::STEP_W'(1);
                state_next  = ST_SPL_RD;
            end
            ST_FIN_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            busy_reg  <= !((state_next == ST_IDLE) || (state_next == ST_UPDATE));
            done_reg  <= (state_next == ST_UPDATE) || (state_next == ST_FIN_DONE);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

### hdl/lowest_free_gate_interval_allocator.sv
// Top level of the lowest-free-gate interval allocator: two gate pools and a best-split walk.
//
//   channel   handshake             payload              transaction
//   request   start / busy          req   (req_t)        start high while busy low
//   result    done (strobe)         rsp   (rsp_t)        one cycle, cannot be stalled
//   config    cfg_we                cfg_data (9 bits)    any edge with cfg_we high
//
// Requests: the 256-wide compare is registered at the accepting edge, the encoder result
// then together with the result strobe; the next transaction is taken in the strobe cycle.
// Finish: class B is totalled over n gates, then every split is read, summed and compared;
// strobe in FIN_DONE, next transaction in the cycle after; n is the effective gate count.
// Undefined command: result strobe in the next cycle.
// Reset: a clearing pass over all 256 entries zeroes the use-count RAMs with busy held high.
module lowest_free_gate_interval_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  lfgia_pkg::req_t              req,
    output logic                         done,
    output lfgia_pkg::rsp_t              rsp,
    input  logic                         cfg_we,
    input  logic [lfgia_pkg::CFG_W-1:0]  cfg_data
);

    lfgia_pkg::ctl_cmd_t ctl;
    lfgia_pkg::dp_stat_t stat;

    lfgia_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (req.cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    lfgia_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req),
        .ctl      (ctl),
        .stat     (stat),
        .rsp      (rsp)
    );

    a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((req.cmd == lfgia_pkg::CMD_REQ_A) ||
                            (req.cmd == lfgia_pkg::CMD_REQ_B))) |-> ##2 done)
        else $error("request transaction did not produce a result two cycles later");

    a_placed_gate: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.placed == (rsp.gate != '0)))
        else $error("placed flag disagrees with gate number");

    a_req_no_best: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.placed) |-> (rsp.best_total == '0))
        else $error("placed request carries a nonzero best total");

    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.spl_rd || ctl.sum_rd || ctl.clr) |-> busy)
        else $error("gate walk running while transactions are accepted");

endmodule

### bench/tb_lowest_free_gate_interval_allocator.sv
// Self-checking testbench for the lowest-free-gate interval allocator with a gate-pool scoreboard.
module tb_lowest_free_gate_interval_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import lfgia_pkg::*;

    localparam logic [1:0] CMD_UNDEF       = 2'd3;
    localparam int         POOL_A          = 0;
    localparam int         POOL_B          = 1;
    localparam int         LIMIT_CYCLES    = 10_000_000;
    localparam int         ITEMS_PER_PHASE = 200;
    localparam int         NUM_PHASES      = 8;

    // Two gate pools mirrored in software; every accepted transaction queues one expected result.
    class gate_scoreboard;
        logic [CFG_W-1:0]  gate_count;
        logic [TIME_W-1:0] last_dep [2][MAX_GATES];
        logic [USE_W-1:0]  use_cnt [2][MAX_GATES];
        rsp_t              expected_q [$];
        int                errors;

        function new();
            gate_count = GATE_CNT_RST;
            errors     = 0;
            foreach (last_dep[p, g])
            begin
                last_dep[p][g] = '0;
                use_cnt[p][g]  = '0;
            end
        endfunction

        function int eff_gates();
            return (gate_count > MAX_GATES) ? MAX_GATES : int'(gate_count);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [BEST_W-1:0] best_split();
            longint unsigned sum_a [MAX_GATES+1];
            longint unsigned sum_b [MAX_GATES+1];
            longint unsigned best;
            longint unsigned s;
            int              n;
            n        = eff_gates();
            sum_a[0] = 0;
            sum_b[0] = 0;
            for (int i = 1; i <= n; i++)
            begin
                sum_a[i] = sum_a[i-1] + use_cnt[POOL_A][i-1];
                sum_b[i] = sum_b[i-1] + use_cnt[POOL_B][i-1];
            end
            best = 0;
            for (int i = 0; i <= n; i++)
            begin
                s = sum_a[i] + sum_b[n-i];
                if (s > best)
                    best = s;
            end
            return (best > BEST_MAX) ? BEST_MAX : best[BEST_W-1:0];
        endfunction

        function void note(req_t r);
            rsp_t e;
            int   pool;
            bit   found;
            e     = '0;
            found = 1'b0;
            if (r.cmd == CMD_REQ_A || r.cmd == CMD_REQ_B)
            begin
                pool = (r.cmd == CMD_REQ_B) ? POOL_B : POOL_A;
                // take the lowest gate whose last departure is at or before the arrival
                for (int g = 0; g < eff_gates() && !found; g++)
                begin
                    if (last_dep[pool][g] <= r.arrival)
                    begin
                        last_dep[pool][g] = r.departure;
                        if (use_cnt[pool][g] != USE_MAX)
                            use_cnt[pool][g] = use_cnt[pool][g] + 1'b1;
                        e.placed = 1'b1;
                        e.gate   = CFG_W'(g + 1);
                        found    = 1'b1;
                    end
                end
            end
            else if (r.cmd == CMD_FINISH)
            begin
                e.best_total = best_split();
            end
            expected_q.push_back(e);
        endfunction

        function void check(rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transaction: placed %0d gate %0d best_total %0d",
                       got.placed, got.gate, got.best_total);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.placed !== e.placed)
            begin
                $error("placed: expected %0d, actual %0d", e.placed, got.placed);
                errors++;
            end
            if (got.gate !== e.gate)
            begin
                $error("gate: expected %0d, actual %0d", e.gate, got.gate);
                errors++;
            end
            if (got.best_total !== e.best_total)
            begin
                $error("best_total: expected %0d, actual %0d", e.best_total, got.best_total);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             req;
    logic             done;
    rsp_t             rsp;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    gate_scoreboard    sb = new();
    int unsigned       cycle_cnt = 0;
    logic [TIME_W-1:0] cursor [2];
    int                calm_left = 0;

    always #5 clk = ~clk;

    lowest_free_gate_interval_allocator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(rsp);
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("tb_lowest_free_gate_interval_allocator: errors");
            $finish;
        end
    end

    function automatic req_t mk(logic [1:0] c, logic [TIME_W-1:0] a, logic [TIME_W-1:0] d);
        req_t r;
        r.cmd       = c;
        r.arrival   = a;
        r.departure = d;
        return r;
    endfunction

    // Mostly sorted traffic per class; the rest is finish, undefined commands and scattered times.
    function automatic req_t random_item(int unsigned span, bit wild);
        req_t        r;
        int unsigned pick;
        int          pool;
        pick = $urandom_range(0, 99);
        pool = $urandom_range(POOL_A, POOL_B);
        r    = mk((pool == POOL_B) ? CMD_REQ_B : CMD_REQ_A, '0, '0);
        if (pick < 2)
        begin
            r = mk(CMD_FINISH, $urandom, $urandom);
        end
        else if (pick < 4)
        begin
            r = mk(CMD_UNDEF, $urandom, $urandom);
        end
        else if (pick < 10)
        begin
            r.arrival   = $urandom_range(0, 1) ? $urandom : $urandom_range(0, cursor[pool]);
            // far departures block a gate for good, so allow them only with plenty of gates
            r.departure = (wild && $urandom_range(0, 1)) ? $urandom
                                                         : $urandom_range(0, cursor[pool] + 64);
        end
        else
        begin
            cursor[pool] = cursor[pool] + $urandom_range(0, 3);
            r.arrival    = cursor[pool];
            r.departure  = cursor[pool] + $urandom_range(1, span);
        end
        return r;
    endfunction

    task automatic send(req_t r);
        int gap;
        if (calm_left > 0)
        begin
            gap = 0;
            calm_left--;
        end
        else
        begin
            gap = $urandom_range(0, 14);
            if ($urandom_range(0, 15) == 0)
                calm_left = $urandom_range(10, 60);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req   = r;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note(r);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic set_gate_count(logic [CFG_W-1:0] v);
        drain_results();
        repeat (4) @(negedge clk);
        cfg_data = v;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we   = 1'b0;
        sb.gate_count = v;
    endtask

    initial
    begin
        int unsigned gc_list [NUM_PHASES];
        int          counted;
        req_t        item;

        gc_list  = '{1, 3, 0, 8, 40, 256, 511, 300};
        rst_n    = 1'b0;
        start    = 1'b0;
        req      = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty pools, undefined command, time extremes at the reset gate count
        send(mk(CMD_FINISH, '0, '0));
        send(mk(CMD_UNDEF, '1, '1));
        send(mk(CMD_REQ_A, '0, '1));
        send(mk(CMD_REQ_A, '0, '0));
        send(mk(CMD_REQ_A, '1, '0));
        send(mk(CMD_REQ_B, '1, '1));
        send(mk(CMD_REQ_B, '1, '0));
        send(mk(CMD_REQ_B, 32'd5, 32'd5));
        send(mk(CMD_FINISH, 32'h5555_5555, 32'hAAAA_AAAA));

        // two gates: fill, refuse, reuse on an equal departure, unsorted arrival
        set_gate_count(CFG_W'(2));
        send(mk(CMD_REQ_A, 32'd10, 32'd100));
        send(mk(CMD_REQ_A, 32'd20, 32'd30));
        send(mk(CMD_REQ_A, 32'd25, 32'd40));
        send(mk(CMD_REQ_A, 32'd30, 32'd60));
        send(mk(CMD_REQ_B, 32'd7, 32'd3));
        send(mk(CMD_REQ_B, 32'd2, 32'd9));
        send(mk(CMD_REQ_B, 32'd1, 32'd4));
        send(mk(CMD_FINISH, '0, '0));
        send(mk(CMD_UNDEF, '0, '0));

        cursor[POOL_A] = 32'd1000;
        cursor[POOL_B] = 32'd1000;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_gate_count(CFG_W'(gc_list[p]));
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                item = random_item(2 * sb.eff_gates() + 6, gc_list[p] >= MAX_GATES);
                send(item);
                if (item.cmd != CMD_UNDEF)
                    counted++;
                // hold off now and then until the block has answered everything
                if ($urandom_range(0, 199) == 0)
                    drain_results();
            end
            send(mk(CMD_FINISH, $urandom, $urandom));
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_lowest_free_gate_interval_allocator: clean");
        else
            $display("tb_lowest_free_gate_interval_allocator: errors");
        $finish;
    end

endmodule

### files.f
hdl/lfgia_pkg.sv
hdl/lfgia_ram.sv
hdl/lfgia_datapath.sv
hdl/lfgia_ctrl.sv
hdl/lowest_free_gate_interval_allocator.sv
bench/tb_lowest_free_gate_interval_allocator.sv
